/* design/esd_pkg.sv */
package esd_pkg;

  // output queue depth between the decoder and the output stage
  localparam int unsigned ESD_QUEUE_DEPTH = 4;

  // longest octal escape, in digits
  localparam logic [2:0] OCT_DIGITS_MAX = 3'd4;

  // error codes carried on the result channel
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TRAILING = 3'd1;
  localparam logic [2:0] ERR_NO_OCT   = 3'd2;
  localparam logic [2:0] ERR_NO_HEX   = 3'd3;
  localparam logic [2:0] ERR_OCT_BIG  = 3'd4;

  // special bytes
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_OCT,
    MODE_HEX1,
    MODE_HEX2,
    MODE_DROP
  } mode_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       has;
    logic [2:0] err;
    logic       last;
  } result_t;

  // one queue entry: the results caused by one item
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic is_oct(input logic [7:0] c);
    return c inside {[8'h30:8'h37]};
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // single-letter escapes; anything else stands for itself
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "a":     r = 8'd7;
      "b":     r = 8'd8;
      "f":     r = 8'd12;
      "n":     r = 8'd10;
      "r":     r = 8'd13;
      "t":     r = 8'd9;
      "v":     r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic result_t mk_char(input logic [7:0] c);
    result_t r;
    r.chr  = c;
    r.has  = 1'b1;
    r.err  = ERR_NONE;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_err(input logic [2:0] e);
    result_t r;
    r.chr  = 8'd0;
    r.has  = 1'b0;
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

/* design/esd_if.sv */
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic [2:0] error_code;
  logic       out_last;

  modport source (output valid, output out_char, output has_char, output error_code,
                  output out_last, input ready);
  modport sink   (input valid, input out_char, input has_char, input error_code,
                  input out_last, output ready);
endinterface

/* design/esd_front.sv */
module esd_front (
  input  logic            clk,
  input  logic            rst_n,
  esd_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output esd_pkg::entry_t push_entry
);
  import esd_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [11:0] acc_r, acc_nxt;

  logic [7:0]  c;
  logic        last;
  logic        accept;
  logic        dig_oct;
  hex_t        hx;
  logic [11:0] acc_shift;
  logic [2:0]  cnt_inc;
  logic        oct_done;
  logic        acc_big;
  logic        shift_big;
  logic        pl_emit;
  result_t     pl_res;
  mode_t       pl_mode;
  logic [1:0]  n_res;
  result_t     r0, r1;

  assign c      = in_ch.in_char;
  assign last   = in_ch.in_last;
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !q_full;

  // digit classification and number arithmetic
  assign dig_oct   = is_oct(c);
  assign hx        = hex_digit(c);
  assign acc_shift = {acc_r[8:0], c[2:0]};
  assign cnt_inc   = count_r + 3'd1;
  assign oct_done  = (cnt_inc >= OCT_DIGITS_MAX) || last;
  assign acc_big   = |acc_r[11:8];
  assign shift_big = |acc_shift[11:8];

  // a byte taken as plain text
  assign pl_emit = (c != CH_BSLASH) || last;
  assign pl_res  = (c == CH_BSLASH) ? mk_err(ERR_TRAILING) : mk_char(c);
  assign pl_mode = (c == CH_BSLASH) ? (last ? MODE_DROP : MODE_ESC) : MODE_PLAIN;

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    case (mode_r)
      MODE_PLAIN: begin
        mode_nxt = pl_mode;
      end
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        if (!last && (c == CH_ZERO || c == CH_X)) begin
          mode_nxt  = (c == CH_ZERO) ? MODE_OCT : MODE_HEX1;
          count_nxt = 3'd0;
          acc_nxt   = 12'd0;
        end
      end
      MODE_OCT: begin
        if (dig_oct) begin
          acc_nxt   = acc_shift;
          count_nxt = cnt_inc;
          if (oct_done) begin
            mode_nxt = shift_big ? MODE_DROP : MODE_PLAIN;
          end
        end else begin
          mode_nxt = acc_big ? MODE_DROP : pl_mode;
        end
      end
      MODE_HEX1: begin
        if (hx.ok) begin
          acc_nxt   = {8'd0, hx.val};
          count_nxt = 3'd1;
          mode_nxt  = last ? MODE_PLAIN : MODE_HEX2;
        end else begin
          mode_nxt = pl_mode;
        end
      end
      MODE_HEX2: begin
        mode_nxt = hx.ok ? MODE_PLAIN : pl_mode;
      end
      MODE_DROP: begin
        mode_nxt = MODE_DROP;
      end
      default: begin
        mode_nxt = pl_mode;
      end
    endcase
    // end of segment returns to reset state
    if (last) begin
      mode_nxt  = MODE_PLAIN;
      count_nxt = 3'd0;
      acc_nxt   = 12'd0;
    end
  end

  // results caused by this item
  always_comb begin
    n_res = 2'd0;
    r0    = '0;
    r1    = '0;
    case (mode_r)
      MODE_PLAIN: begin
        n_res = pl_emit ? 2'd1 : 2'd0;
        r0    = pl_res;
      end
      MODE_ESC: begin
        if (c == CH_ZERO) begin
          n_res = last ? 2'd1 : 2'd0;
          r0    = mk_err(ERR_NO_OCT);
        end else if (c == CH_X) begin
          n_res = last ? 2'd1 : 2'd0;
          r0    = mk_err(ERR_NO_HEX);
        end else begin
          n_res = 2'd1;
          r0    = mk_char(esc_map(c));
        end
      end
      MODE_OCT: begin
        if (dig_oct) begin
          n_res = oct_done ? 2'd1 : 2'd0;
          r0    = shift_big ? mk_err(ERR_OCT_BIG) : mk_char(acc_shift[7:0]);
        end else if (acc_big) begin
          n_res = 2'd1;
          r0    = mk_err(ERR_OCT_BIG);
        end else begin
          n_res = pl_emit ? 2'd2 : 2'd1;
          r0    = mk_char(acc_r[7:0]);
          r1    = pl_res;
        end
      end
      MODE_HEX1: begin
        if (hx.ok) begin
          n_res = last ? 2'd1 : 2'd0;
          r0    = mk_char({4'd0, hx.val});
        end else begin
          n_res = pl_emit ? 2'd2 : 2'd1;
          r0    = mk_char(CH_X);
          r1    = pl_res;
        end
      end
      MODE_HEX2: begin
        if (hx.ok) begin
          n_res = 2'd1;
          r0    = mk_char({acc_r[3:0], hx.val});
        end else begin
          n_res = pl_emit ? 2'd2 : 2'd1;
          r0    = mk_char({4'd0, acc_r[3:0]});
          r1    = pl_res;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
    // the final byte always gives at least one result, flagged last
    if (last) begin
      if (n_res == 2'd0) begin
        n_res = 2'd1;
        r0    = '0;
      end
      if (n_res == 2'd2) begin
        r1.last = 1'b1;
      end else begin
        r0.last = 1'b1;
      end
    end
  end

  assign push            = accept && (n_res != 2'd0);
  assign push_entry.two  = (n_res == 2'd2);
  assign push_entry.r0   = r0;
  assign push_entry.r1   = r1;

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      count_r <= 3'd0;
      acc_r   <= 12'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_seg_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> mode_r == MODE_PLAIN && acc_r == 12'd0 && count_r == 3'd0)
    else $error("decoder state not cleared after final byte");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.two |-> !push_entry.r0.last)
    else $error("first of two results flagged last");
`endif

endmodule

/* design/esd_queue.sv */
module esd_queue #(
  parameter int unsigned DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esd_pkg::entry_t push_entry,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output esd_pkg::entry_t pop_entry
);
  import esd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = slots_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");
`endif

endmodule

/* design/esd_back.sv */
module esd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  esd_pkg::entry_t q_entry,
  output logic            pop,
  esd_out_if.source       out_ch
);
  import esd_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    sec_valid_r;
  result_t sec_data_r;
  logic    adv;

  // output register free to take the next result
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && !sec_valid_r && !q_empty;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_data_r.chr;
  assign out_ch.has_char   = out_data_r.has;
  assign out_ch.error_code = out_data_r.err;
  assign out_ch.out_last   = out_data_r.last;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else if (adv) begin
      if (sec_valid_r) begin
        out_valid_r <= 1'b1;
        sec_valid_r <= 1'b0;
      end else begin
        out_valid_r <= !q_empty;
        sec_valid_r <= !q_empty && q_entry.two;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sec_valid_r) begin
        out_data_r <= sec_data_r;
      end else if (!q_empty) begin
        out_data_r <= q_entry.r0;
        sec_data_r <= q_entry.r1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_second_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> out_valid_r)
    else $error("second result pending with empty output register");
`endif

endmodule

/* design/escape_sequence_decoder.sv */
// Escape sequence decoder: turns a text segment with backslash escapes into
// decoded bytes and error reports.
// Input channel in_ch: one byte per item (in_char) with in_last on the final
// byte of a segment. Result channel out_ch: out_char/has_char for a decoded
// byte, error_code for an error, out_last on the final result of a segment.
// An item gives zero, one or two results; the final byte always gives at least one.
// A result passes through the queue and then the output register before it
// is valid on out_ch.
// Throughput: one item every cycle while the queue has room; an item with
// two results holds the output register for both of them, and the
// QUEUE_DEPTH-entry queue between decoder and output stage absorbs that.
// When out_ch is stalled the queue fills and in_ch.ready drops once it is
// full; nothing is lost. A result waits in the output register while the
// decoder keeps taking items.
// Reset (rst_n low, synchronous) empties the queue and the output register
// and puts the decoder back in plain text mode.
module escape_sequence_decoder #(
  parameter int unsigned QUEUE_DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);
  import esd_pkg::*;

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t pop_entry;

  esd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .empty      (q_empty),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  esd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_entry (pop_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* tb/escape_sequence_decoder_tb.sv */
`timescale 1ns / 100ps

module escape_sequence_decoder_tb;
  import esd_pkg::*;

  localparam int unsigned LONG_STALL     = 80;
  localparam int unsigned QUIET_LIMIT    = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned PHASE_BYTES    = 370;
  localparam int unsigned NUM_PHASES     = 5;
  localparam int unsigned PRINT_CAP      = 100;

  // how an item's results are checked
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } row_check_t;

  typedef struct {
    logic [7:0] chr;
    logic       last;
    row_check_t chk;
    logic [7:0] e_chr;
    logic       e_has;
    logic [2:0] e_err;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n;

  esd_in_if  in_bus ();
  esd_out_if out_bus ();

  escape_sequence_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // directed segments; typed results only where they are obvious
  text_row_t directed_rows [29] = '{
    '{8'h00,     1'b0, CHK_ONE,     8'h00, 1'b1, ERR_NONE},
    '{8'hff,     1'b1, CHK_ONE,     8'hff, 1'b1, ERR_NONE},
    '{CH_BSLASH, 1'b1, CHK_ONE,     8'h00, 1'b0, ERR_TRAILING},
    '{CH_BSLASH, 1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{CH_ZERO,   1'b1, CHK_ONE,     8'h00, 1'b0, ERR_NO_OCT},
    '{CH_BSLASH, 1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{CH_X,      1'b1, CHK_ONE,     8'h00, 1'b0, ERR_NO_HEX},
    // four octal sevens overflow, then the final byte is dropped
    '{CH_BSLASH, 1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{CH_ZERO,   1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{"7",       1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{"7",       1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{"7",       1'b0, CHK_NONE,    8'h00, 1'b0, ERR_NONE},
    '{"7",       1'b0, CHK_ONE,     8'h00, 1'b0, ERR_OCT_BIG},
    '{"A",       1'b1, CHK_ONE,     8'h00, 1'b0, ERR_NONE},
    // octal with no digit
    '{CH_BSLASH, 1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{CH_ZERO,   1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"q",       1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    // hex with no digit
    '{CH_BSLASH, 1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{CH_X,      1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"z",       1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    // short hex closed by a plain byte
    '{CH_BSLASH, 1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{CH_X,      1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"a",       1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"G",       1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    // three-digit octal 377, the largest that fits, closed by the final byte
    '{CH_BSLASH, 1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{CH_ZERO,   1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"3",       1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"7",       1'b0, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE},
    '{"7",       1'b1, CHK_PREDICT, 8'h00, 1'b0, ERR_NONE}
  };

  text_row_t   text_rows [$];
  text_row_t   cur_row;
  result_t     decoded_results [$];
  result_t     step_out [$];

  // decoder state kept by the predictor
  mode_t       dec_mode;
  logic [2:0]  oct_digits;
  logic [11:0] num_acc;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned stall_requests;
  int unsigned stall_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void put_result(input logic [7:0] c, input logic has,
                                     input logic [2:0] e);
    result_t r;
    r.chr  = has ? c : 8'h00;
    r.has  = has;
    r.err  = e;
    r.last = 1'b0;
    step_out.insert(step_out.size(), r);
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void plain_in(input logic [7:0] c, input logic last);
    if (c == CH_BSLASH) begin
      if (last) begin
        put_result(8'h00, 1'b0, ERR_TRAILING);
        dec_mode = MODE_DROP;
      end else begin
        dec_mode = MODE_ESC;
      end
    end else begin
      put_result(c, 1'b1, ERR_NONE);
      dec_mode = MODE_PLAIN;
    end
  endfunction

  function automatic bit close_octal();
    if (num_acc > 12'd255) begin
      put_result(8'h00, 1'b0, ERR_OCT_BIG);
      dec_mode = MODE_DROP;
      return 1'b0;
    end
    put_result(num_acc[7:0], 1'b1, ERR_NONE);
    dec_mode = MODE_PLAIN;
    return 1'b1;
  endfunction

  // results caused by one byte, left in step_out
  function automatic void decode_item(input logic [7:0] c, input logic last);
    int h;
    step_out.delete();
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_PLAIN;
        case (c)
          "a": put_result(8'd7, 1'b1, ERR_NONE);
          "b": put_result(8'd8, 1'b1, ERR_NONE);
          "f": put_result(8'd12, 1'b1, ERR_NONE);
          "n": put_result(8'd10, 1'b1, ERR_NONE);
          "r": put_result(8'd13, 1'b1, ERR_NONE);
          "t": put_result(8'd9, 1'b1, ERR_NONE);
          "v": put_result(8'd11, 1'b1, ERR_NONE);
          CH_ZERO: begin
            if (last) begin
              put_result(8'h00, 1'b0, ERR_NO_OCT);
            end else begin
              dec_mode   = MODE_OCT;
              oct_digits = 3'd0;
              num_acc    = 12'd0;
            end
          end
          CH_X: begin
            if (last) begin
              put_result(8'h00, 1'b0, ERR_NO_HEX);
            end else begin
              dec_mode   = MODE_HEX1;
              oct_digits = 3'd0;
              num_acc    = 12'd0;
            end
          end
          default: put_result(c, 1'b1, ERR_NONE);
        endcase
      end
      MODE_OCT: begin
        if (c >= "0" && c <= "7") begin
          num_acc    = {num_acc[8:0], c[2:0]};
          oct_digits = oct_digits + 3'd1;
          if (oct_digits >= OCT_DIGITS_MAX || last) void'(close_octal());
        end else if (close_octal()) begin
          plain_in(c, last);
        end
      end
      MODE_HEX1: begin
        h = hex_nibble(c);
        if (h >= 0) begin
          num_acc    = 12'(h);
          oct_digits = 3'd1;
          if (last) begin
            put_result(num_acc[7:0], 1'b1, ERR_NONE);
            dec_mode = MODE_PLAIN;
          end else begin
            dec_mode = MODE_HEX2;
          end
        end else begin
          put_result(CH_X, 1'b1, ERR_NONE);
          dec_mode = MODE_PLAIN;
          plain_in(c, last);
        end
      end
      MODE_HEX2: begin
        h = hex_nibble(c);
        dec_mode = MODE_PLAIN;
        if (h >= 0) begin
          put_result({num_acc[3:0], 4'(h)}, 1'b1, ERR_NONE);
        end else begin
          put_result({4'h0, num_acc[3:0]}, 1'b1, ERR_NONE);
          plain_in(c, last);
        end
      end
      MODE_DROP: begin
      end
      default: plain_in(c, last);
    endcase
    // the final byte always closes with exactly one flagged result
    if (last) begin
      if (step_out.size() == 0) put_result(8'h00, 1'b0, ERR_NONE);
      step_out[step_out.size() - 1].last = 1'b1;
      dec_mode   = MODE_PLAIN;
      oct_digits = 3'd0;
      num_acc    = 12'd0;
    end
  endfunction

  function automatic void queue_row(input text_row_t row);
    text_rows.insert(text_rows.size(), row);
    bytes_queued++;
  endfunction

  // one random segment built from plain bytes and escape tokens, sometimes cut short
  task automatic add_segment();
    string      esc_letters;
    string      hex_chars;
    logic [7:0] seg [$];
    logic [7:0] c;
    text_row_t  row;
    int         ntok;
    int         kind;
    int         nd;
    int         cut;
    esc_letters = "abfnrtv\"\\";
    hex_chars   = "0123456789abcdefABCDEF";
    ntok = $urandom_range(8, 1);
    for (int k = 0; k < ntok; k++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        c = 8'($urandom_range(126, 32));
        if (c == CH_BSLASH) c = ".";
        seg.insert(seg.size(), c);
      end else if (kind < 50) begin
        seg.insert(seg.size(), CH_BSLASH);
        seg.insert(seg.size(), esc_letters[$urandom_range(esc_letters.len() - 1)]);
      end else if (kind < 65) begin
        seg.insert(seg.size(), CH_BSLASH);
        seg.insert(seg.size(), CH_ZERO);
        nd = $urandom_range(4);
        for (int d = 0; d < nd; d++) seg.insert(seg.size(), 8'("0" + $urandom_range(7)));
      end else if (kind < 80) begin
        seg.insert(seg.size(), CH_BSLASH);
        seg.insert(seg.size(), CH_X);
        nd = $urandom_range(2);
        for (int d = 0; d < nd; d++) begin
          seg.insert(seg.size(), hex_chars[$urandom_range(hex_chars.len() - 1)]);
        end
      end else if (kind < 90) begin
        seg.insert(seg.size(), CH_BSLASH);
        seg.insert(seg.size(), 8'($urandom_range(255)));
      end else begin
        seg.insert(seg.size(), 8'($urandom_range(255)));
      end
    end
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(seg.size(), 1);
      while (seg.size() > cut) seg.delete(seg.size() - 1);
    end
    row.chk   = CHK_PREDICT;
    row.e_chr = 8'h00;
    row.e_has = 1'b0;
    row.e_err = ERR_NONE;
    foreach (seg[i]) begin
      row.chr  = seg[i];
      row.last = (i == seg.size() - 1);
      queue_row(row);
    end
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || decoded_results.size() != 0) @(posedge clk);
  endtask

  // sender: offers the next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid   <= 1'b0;
      in_bus.in_char <= 8'h00;
      in_bus.in_last <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        decode_item(cur_row.chr, cur_row.last);
        case (cur_row.chk)
          CHK_PREDICT: begin
            foreach (step_out[i]) decoded_results.insert(decoded_results.size(), step_out[i]);
          end
          CHK_ONE: decoded_results.insert(decoded_results.size(),
                                          result_t'{cur_row.e_chr, cur_row.e_has,
                                                    cur_row.e_err, cur_row.last});
          default: begin
          end
        endcase
        bytes_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (text_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_row = text_rows.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.in_char <= cur_row.chr;
          in_bus.in_last <= cur_row.last;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      hold_left    = LONG_STALL;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (decoded_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = decoded_results.pop_front();
        if (out_bus.out_char !== want.chr)
          report_mismatch($sformatf("out_char %h, want %h", out_bus.out_char, want.chr));
        if (out_bus.has_char !== want.has)
          report_mismatch($sformatf("has_char %b, want %b", out_bus.has_char, want.has));
        if (out_bus.error_code !== want.err)
          report_mismatch($sformatf("error_code %0d, want %0d", out_bus.error_code,
                                    want.err));
        if (out_bus.out_last !== want.last)
          report_mismatch($sformatf("out_last %b, want %b", out_bus.out_last, want.last));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned send_pct [NUM_PHASES];
    int unsigned recv_pct [NUM_PHASES];
    int unsigned target;
    send_pct = '{0, 46, 0, 36, 0};
    recv_pct = '{0, 0, 46, 36, 0};
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_char = 8'h00;
    in_bus.in_last = 1'b0;
    out_bus.ready  = 1'b0;
    dec_mode       = MODE_PLAIN;
    oct_digits     = 3'd0;
    num_acc        = 12'd0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    bytes_queued   = 0;
    bytes_taken    = 0;
    stall_requests = 0;
    stall_served   = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    mismatches     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed segments, no idling
    foreach (directed_rows[i]) queue_row(directed_rows[i]);
    wait_drained();

    // random phases; the sender waits for every result between phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) add_segment();
      // last phase: long receiver hold-off while the sender keeps offering
      if (p == NUM_PHASES - 1) stall_requests++;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", decoded_results.size()));
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
